// ===== src/rdc_pkg.sv =====
`timescale 1ns / 1ps

package rdc_pkg;

  typedef logic [5:0] kind_t;
  typedef logic [5:0] alu_op_t;

  // Major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_SR   = 3'd5;

  // Instruction kinds
  localparam kind_t K_ILLEGAL = 6'd0;
  localparam kind_t K_LUI     = 6'd1;
  localparam kind_t K_AUIPC   = 6'd2;
  localparam kind_t K_SLLI    = 6'd9;
  localparam kind_t K_SRLI    = 6'd10;
  localparam kind_t K_SRAI    = 6'd11;
  localparam kind_t K_SUB     = 6'd13;
  localparam kind_t K_SRA     = 6'd19;
  localparam kind_t K_SB      = 6'd27;
  localparam kind_t K_SH      = 6'd28;
  localparam kind_t K_SW      = 6'd29;
  localparam kind_t K_JAL     = 6'd30;
  localparam kind_t K_JALR    = 6'd31;
  localparam kind_t K_MUL     = 6'd38;

  // ALU operations
  localparam alu_op_t ALU_ADDI  = 6'd0;
  localparam alu_op_t ALU_SLLI  = 6'd6;
  localparam alu_op_t ALU_SRLI  = 6'd7;
  localparam alu_op_t ALU_SRAI  = 6'd8;
  localparam alu_op_t ALU_ADD   = 6'd9;
  localparam alu_op_t ALU_SUB   = 6'd10;
  localparam alu_op_t ALU_SRA   = 6'd16;
  localparam alu_op_t ALU_MUL   = 6'd25;
  localparam alu_op_t ALU_LUI   = 6'd33;
  localparam alu_op_t ALU_JALR  = 6'd34;
  localparam alu_op_t ALU_STORE = 6'd36;

  // Next PC select
  localparam logic [1:0] PC_JALR   = 2'd0;
  localparam logic [1:0] PC_BRANCH = 2'd1;
  localparam logic [1:0] PC_JAL    = 2'd2;
  localparam logic [1:0] PC_SEQ    = 2'd3;

  // Writeback source
  localparam logic [2:0] WB_ALU  = 3'd0;
  localparam logic [2:0] WB_LINK = 3'd4;

  // Byte write masks
  localparam logic [3:0] MASK_NONE = 4'd0;
  localparam logic [3:0] MASK_BYTE = 4'd1;
  localparam logic [3:0] MASK_HALF = 4'd3;
  localparam logic [3:0] MASK_WORD = 4'd15;

  // Per-funct3 tables; a zero kind marks an unused code
  localparam kind_t   OP_KIND  [0:7] = '{6'd12, 6'd14, 6'd15, 6'd16,
                                         6'd17, 6'd18, 6'd20, 6'd21};
  localparam alu_op_t OP_ALU   [0:7] = '{6'd9, 6'd11, 6'd12, 6'd13,
                                         6'd14, 6'd15, 6'd17, 6'd18};
  localparam kind_t   IMM_KIND [0:7] = '{6'd3, 6'd0, 6'd4, 6'd5,
                                         6'd6, 6'd0, 6'd7, 6'd8};
  localparam alu_op_t IMM_ALU  [0:7] = '{6'd0, 6'd0, 6'd1, 6'd2,
                                         6'd3, 6'd0, 6'd4, 6'd5};
  localparam kind_t   LD_KIND  [0:7] = '{6'd22, 6'd23, 6'd24, 6'd0,
                                         6'd25, 6'd26, 6'd0, 6'd0};
  localparam logic [2:0] LD_SEL [0:7] = '{3'd3, 3'd2, 3'd1, 3'd0,
                                          3'd3, 3'd2, 3'd0, 3'd0};
  localparam kind_t   BR_KIND  [0:7] = '{6'd32, 6'd33, 6'd0, 6'd0,
                                         6'd34, 6'd35, 6'd36, 6'd37};
  localparam alu_op_t BR_ALU   [0:7] = '{6'd19, 6'd20, 6'd0, 6'd0,
                                         6'd21, 6'd22, 6'd23, 6'd24};

  typedef struct packed {
    kind_t      instr_kind;
    logic [1:0] pc_mux_sel;
    logic       reg_write_en;
    logic [2:0] reg_input_sel;
    logic       pc_add_sel;
    logic [3:0] data_write_mask;
    logic       alu_input_sel;
    alu_op_t    alu_op;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [31:0] immediate_value;
  } result_t;

  function automatic ctl_t mk_ctl(kind_t kind, logic [1:0] pc, logic we,
                                  logic [2:0] rin, logic [3:0] mask,
                                  logic ain, alu_op_t op);
    ctl_t c;
    c.instr_kind      = kind;
    c.pc_mux_sel      = pc;
    c.reg_write_en    = we;
    c.reg_input_sel   = rin;
    c.pc_add_sel      = 1'b0;
    c.data_write_mask = mask;
    c.alu_input_sel   = ain;
    c.alu_op          = op;
    return c;
  endfunction

endpackage

// ===== src/rdc_if.sv =====
`timescale 1ns / 1ps

interface rdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface rdc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  instr_kind;
  logic [1:0]  pc_mux_sel;
  logic        reg_write_en;
  logic [2:0]  reg_input_sel;
  logic        pc_add_sel;
  logic [3:0]  data_write_mask;
  logic        alu_input_sel;
  logic [5:0]  alu_op;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [31:0] immediate_value;

  modport source (output valid, input ready, output instr_kind, output pc_mux_sel,
                  output reg_write_en, output reg_input_sel, output pc_add_sel,
                  output data_write_mask, output alu_input_sel, output alu_op,
                  output dest_reg, output src_reg_a, output src_reg_b,
                  output immediate_value);
  modport sink (input valid, output ready, input instr_kind, input pc_mux_sel,
                input reg_write_en, input reg_input_sel, input pc_add_sel,
                input data_write_mask, input alu_input_sel, input alu_op,
                input dest_reg, input src_reg_a, input src_reg_b,
                input immediate_value);
endinterface

// ===== src/rv32im_decode_control_top.sv =====
`timescale 1ns / 1ps

// RV32IM instruction decoder for a single-cycle style datapath. Each item on
// in_i is one 32-bit instruction word; each item on out_o is its kind number,
// the datapath controls (next-PC select, register write, writeback source,
// byte write mask, ALU operand select, ALU operation), the rd/rs1/rs2 fields
// and the immediate, sign-extended but for LUI and SRAI. The block takes one
// item per cycle while the output is ready: each item passes the input
// register and then the result register, with the whole decode as short
// logic in between. Both registers keep moving while the output is
// ready, and a stalled result holds the pipe without losing the item in
// flight. Illegal opcodes give kind 0 and zero controls; unmatched funct
// codes give kind 0 but keep the register fields and any immediate (and for
// branches the branch PC select) already decoded. There is no configuration
// and no state besides the two pipeline registers.
module rv32im_decode_control_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  rdc_in_if.sink           in_i,
  rdc_out_if.source        out_o
);
  import rdc_pkg::*;

  logic        in_valid_q;
  logic [31:0] word_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res_d;
  logic        out_adv;
  logic        in_ready;

  // Advance the result register when it is empty or being taken
  assign out_adv  = !out_valid_q || out_o.ready;
  assign in_ready = !in_valid_q || out_adv;
  assign in_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      word_q <= in_i.instr_word;
    end
  end

  // Decode
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] i_imm;
  logic [31:0] s_imm;
  logic [31:0] b_imm;
  logic [31:0] j_imm;

  assign opc   = word_q[6:0];
  assign f3    = word_q[14:12];
  assign f7    = word_q[31:25];
  assign i_imm = {{20{word_q[31]}}, word_q[31:20]};
  assign s_imm = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
  assign b_imm = {{19{word_q[31]}}, word_q[31], word_q[7], word_q[30:25],
                  word_q[11:8], 1'b0};
  assign j_imm = {{11{word_q[31]}}, word_q[31], word_q[19:12], word_q[20],
                  word_q[30:21], 1'b0};

  always_comb begin
    res_d.ctl             = '0;
    res_d.dest_reg        = word_q[11:7];
    res_d.src_reg_a       = word_q[19:15];
    res_d.src_reg_b       = word_q[24:20];
    res_d.immediate_value = '0;
    case (opc)
      OPC_AUIPC: begin
        res_d.ctl = mk_ctl(K_AUIPC, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, ALU_ADD);
        res_d.immediate_value = {{12{word_q[31]}}, word_q[31:12]};
      end
      OPC_LUI: begin
        res_d.ctl = mk_ctl(K_LUI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, ALU_LUI);
        res_d.immediate_value = {12'b0, word_q[31:12]};
      end
      OPC_OP_IMM: begin
        res_d.immediate_value = i_imm;
        if (f3 == F3_SLL) begin
          if (f7 == F7_BASE) begin
            res_d.ctl = mk_ctl(K_SLLI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1,
                               ALU_SLLI);
          end
        end else if (f3 == F3_SR) begin
          if (f7 == F7_BASE) begin
            res_d.ctl = mk_ctl(K_SRLI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1,
                               ALU_SRLI);
          end else if (f7 == F7_ALT) begin
            res_d.ctl = mk_ctl(K_SRAI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1,
                               ALU_SRAI);
            res_d.immediate_value = {27'b0, word_q[24:20]};
          end
        end else if (IMM_KIND[f3] != K_ILLEGAL) begin
          res_d.ctl = mk_ctl(IMM_KIND[f3], PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1,
                             IMM_ALU[f3]);
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          res_d.ctl = mk_ctl(OP_KIND[f3], PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0,
                             OP_ALU[f3]);
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) begin
            res_d.ctl = mk_ctl(K_SUB, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0,
                               ALU_SUB);
          end else if (f3 == F3_SR) begin
            res_d.ctl = mk_ctl(K_SRA, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0,
                               ALU_SRA);
          end
        end else if (f7 == F7_MULDIV) begin
          res_d.ctl = mk_ctl(K_MUL + {3'b0, f3}, PC_SEQ, 1'b1, WB_ALU, MASK_NONE,
                             1'b0, ALU_MUL + {3'b0, f3});
        end
      end
      OPC_LOAD: begin
        res_d.immediate_value = i_imm;
        if (LD_KIND[f3] != K_ILLEGAL) begin
          res_d.ctl = mk_ctl(LD_KIND[f3], PC_SEQ, 1'b1, LD_SEL[f3], MASK_NONE, 1'b1,
                             ALU_ADDI);
        end
      end
      OPC_STORE: begin
        res_d.immediate_value = s_imm;
        if (f3 == F3_ADD) begin
          res_d.ctl = mk_ctl(K_SB, PC_SEQ, 1'b0, WB_ALU, MASK_BYTE, 1'b1, ALU_STORE);
        end else if (f3 == F3_SLL) begin
          res_d.ctl = mk_ctl(K_SH, PC_SEQ, 1'b0, WB_ALU, MASK_HALF, 1'b1, ALU_STORE);
        end else if (f3 == F3_WORD) begin
          res_d.ctl = mk_ctl(K_SW, PC_SEQ, 1'b0, WB_ALU, MASK_WORD, 1'b1, ALU_STORE);
          // drop rd for word stores
          res_d.dest_reg = '0;
        end
      end
      OPC_JAL: begin
        res_d.ctl = mk_ctl(K_JAL, PC_JAL, 1'b1, WB_LINK, MASK_NONE, 1'b0, ALU_ADDI);
        res_d.immediate_value = j_imm;
      end
      OPC_JALR: begin
        if (f3 == F3_ADD) begin
          res_d.ctl = mk_ctl(K_JALR, PC_JALR, 1'b1, WB_LINK, MASK_NONE, 1'b1,
                             ALU_JALR);
          res_d.immediate_value = i_imm;
        end
      end
      OPC_BRANCH: begin
        // keep the branch PC select even for unused funct3 codes
        res_d.ctl = mk_ctl(BR_KIND[f3], PC_BRANCH, 1'b0, WB_ALU, MASK_NONE, 1'b0,
                           BR_ALU[f3]);
        res_d.immediate_value = b_imm;
      end
      default: begin
        res_d.ctl = '0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.instr_kind      = res_q.ctl.instr_kind;
  assign out_o.pc_mux_sel      = res_q.ctl.pc_mux_sel;
  assign out_o.reg_write_en    = res_q.ctl.reg_write_en;
  assign out_o.reg_input_sel   = res_q.ctl.reg_input_sel;
  assign out_o.pc_add_sel      = res_q.ctl.pc_add_sel;
  assign out_o.data_write_mask = res_q.ctl.data_write_mask;
  assign out_o.alu_input_sel   = res_q.ctl.alu_input_sel;
  assign out_o.alu_op          = res_q.ctl.alu_op;
  assign out_o.dest_reg        = res_q.dest_reg;
  assign out_o.src_reg_a       = res_q.src_reg_a;
  assign out_o.src_reg_b       = res_q.src_reg_b;
  assign out_o.immediate_value = res_q.immediate_value;

`ifndef ASSERT_OFF
  // An accepted item lands in the input register
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> in_valid_q)
    else $error("accepted item not captured");

  // A waiting item is not dropped while the result side stalls
  a_hold_inflight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_adv) |=> in_valid_q)
    else $error("item in flight dropped under stall");

  // An item in the input register moves on when the result side advances
  a_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("decoded item not forwarded");

  // Stores never write the register file
  a_store_no_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ctl.data_write_mask != MASK_NONE) |->
      !res_q.ctl.reg_write_en)
    else $error("store with register write");

  // An illegal kind carries no write side effects
  a_illegal_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ctl.instr_kind == K_ILLEGAL) |->
      (!res_q.ctl.reg_write_en && res_q.ctl.data_write_mask == MASK_NONE))
    else $error("illegal item with side effects");
`endif

endmodule

// ===== test/tb_rv32im_decode_control_top.sv =====
`timescale 1ns / 1ps

module tb_rv32im_decode_control_top;
  import rdc_pkg::*;

  // Instruction kinds and ALU operations as the decoder numbers them
  typedef enum logic [5:0] {
    IK_ILLEGAL, IK_LUI, IK_AUIPC, IK_ADDI, IK_SLTI, IK_SLTIU, IK_XORI, IK_ORI,
    IK_ANDI, IK_SLLI, IK_SRLI, IK_SRAI, IK_ADD, IK_SUB, IK_SLL, IK_SLT, IK_SLTU,
    IK_XOR, IK_SRL, IK_SRA, IK_OR, IK_AND, IK_LB, IK_LH, IK_LW, IK_LBU, IK_LHU,
    IK_SB, IK_SH, IK_SW, IK_JAL, IK_JALR, IK_BEQ, IK_BNE, IK_BLT, IK_BGE,
    IK_BLTU, IK_BGEU, IK_MUL, IK_MULH, IK_MULHSU, IK_MULHU, IK_DIV, IK_DIVU,
    IK_REM, IK_REMU
  } instr_kind_e;

  typedef enum logic [5:0] {
    AL_ADDI, AL_SLTI, AL_SLTIU, AL_XORI, AL_ORI, AL_ANDI, AL_SLLI, AL_SRLI,
    AL_SRAI, AL_ADD, AL_SUB, AL_SLL, AL_SLT, AL_SLTU, AL_XOR, AL_SRL, AL_SRA,
    AL_OR, AL_AND, AL_BEQ, AL_BNE, AL_BLT, AL_BGE, AL_BLTU, AL_BGEU, AL_MUL,
    AL_MULH, AL_MULHSU, AL_MULHU, AL_DIV, AL_DIVU, AL_REM, AL_REMU, AL_LUI,
    AL_JALR, AL_STORE = 6'd36
  } alu_op_e;

  localparam int NUM_KINDS = 46;

  // Writeback sources for loads
  localparam logic [2:0] LD_WORD = 3'd1;
  localparam logic [2:0] LD_HALF = 3'd2;
  localparam logic [2:0] LD_BYTE = 3'd3;

  // Store widths and a funct3 that loads, stores and branches leave unused
  localparam logic [2:0] F3_BYTE   = 3'd0;
  localparam logic [2:0] F3_HALF   = 3'd1;
  localparam logic [2:0] F3_UNUSED = 3'd3;

  // Per-funct3 decode tables of the predictor
  localparam instr_kind_e RR_KIND [0:7] = '{IK_ADD, IK_SLL, IK_SLT, IK_SLTU,
                                            IK_XOR, IK_SRL, IK_OR, IK_AND};
  localparam alu_op_e     RR_OP   [0:7] = '{AL_ADD, AL_SLL, AL_SLT, AL_SLTU,
                                            AL_XOR, AL_SRL, AL_OR, AL_AND};
  localparam instr_kind_e RI_KIND [0:7] = '{IK_ADDI, IK_ILLEGAL, IK_SLTI, IK_SLTIU,
                                            IK_XORI, IK_ILLEGAL, IK_ORI, IK_ANDI};
  localparam alu_op_e     RI_OP   [0:7] = '{AL_ADDI, AL_ADDI, AL_SLTI, AL_SLTIU,
                                            AL_XORI, AL_ADDI, AL_ORI, AL_ANDI};
  localparam instr_kind_e LOAD_KIND [0:7] = '{IK_LB, IK_LH, IK_LW, IK_ILLEGAL,
                                              IK_LBU, IK_LHU, IK_ILLEGAL, IK_ILLEGAL};
  localparam logic [2:0]  LOAD_SRC  [0:7] = '{LD_BYTE, LD_HALF, LD_WORD, WB_ALU,
                                              LD_BYTE, LD_HALF, WB_ALU, WB_ALU};
  localparam instr_kind_e BRANCH_KIND [0:7] = '{IK_BEQ, IK_BNE, IK_ILLEGAL, IK_ILLEGAL,
                                                IK_BLT, IK_BGE, IK_BLTU, IK_BGEU};
  localparam alu_op_e     BRANCH_OP   [0:7] = '{AL_BEQ, AL_BNE, AL_ADDI, AL_ADDI,
                                                AL_BLT, AL_BGE, AL_BLTU, AL_BGEU};

  localparam logic [6:0] OPCODES [0:8] = '{OPC_LOAD, OPC_OP_IMM, OPC_AUIPC, OPC_STORE,
                                           OPC_OP, OPC_LUI, OPC_BRANCH, OPC_JALR,
                                           OPC_JAL};

  // Holds the decodes of accepted words until the block delivers them
  class decode_board;
    result_t decoded_q[$];
    int      errors;
    int      checked;
    bit      kind_seen [NUM_KINDS];

    function ctl_t controls(instr_kind_e kind, logic [1:0] pc, logic we,
                            logic [2:0] src, logic [3:0] mask, logic ain,
                            alu_op_e op);
      ctl_t c;
      c.instr_kind      = kind;
      c.pc_mux_sel      = pc;
      c.reg_write_en    = we;
      c.reg_input_sel   = src;
      c.pc_add_sel      = 1'b0;
      c.data_write_mask = mask;
      c.alu_input_sel   = ain;
      c.alu_op          = op;
      return c;
    endfunction

    function result_t decode_word(logic [31:0] w);
      result_t     r;
      logic [6:0]  opc;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm_i;
      opc   = w[6:0];
      f3    = w[14:12];
      f7    = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      r = '0;
      r.dest_reg  = w[11:7];
      r.src_reg_a = w[19:15];
      r.src_reg_b = w[24:20];
      case (opc)
        OPC_AUIPC: begin
          r.ctl = controls(IK_AUIPC, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, AL_ADD);
          r.immediate_value = {{12{w[31]}}, w[31:12]};
        end
        OPC_LUI: begin
          // upper immediate lands in the low bits, zero above
          r.ctl = controls(IK_LUI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, AL_LUI);
          r.immediate_value = {12'b0, w[31:12]};
        end
        OPC_OP_IMM: begin
          r.immediate_value = imm_i;
          if (f3 == F3_SLL) begin
            if (f7 == F7_BASE)
              r.ctl = controls(IK_SLLI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, AL_SLLI);
          end else if (f3 == F3_SR) begin
            if (f7 == F7_BASE) begin
              r.ctl = controls(IK_SRLI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, AL_SRLI);
            end else if (f7 == F7_ALT) begin
              r.ctl = controls(IK_SRAI, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1, AL_SRAI);
              r.immediate_value = {27'b0, w[24:20]};
            end
          end else if (RI_KIND[f3] != IK_ILLEGAL) begin
            r.ctl = controls(RI_KIND[f3], PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b1,
                             RI_OP[f3]);
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            r.ctl = controls(RR_KIND[f3], PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0,
                             RR_OP[f3]);
          end else if (f7 == F7_ALT) begin
            if (f3 == F3_ADD)
              r.ctl = controls(IK_SUB, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0, AL_SUB);
            else if (f3 == F3_SR)
              r.ctl = controls(IK_SRA, PC_SEQ, 1'b1, WB_ALU, MASK_NONE, 1'b0, AL_SRA);
          end else if (f7 == F7_MULDIV) begin
            r.ctl = controls(instr_kind_e'(IK_MUL + f3), PC_SEQ, 1'b1, WB_ALU,
                             MASK_NONE, 1'b0, alu_op_e'(AL_MUL + f3));
          end
        end
        OPC_LOAD: begin
          r.immediate_value = imm_i;
          if (LOAD_KIND[f3] != IK_ILLEGAL)
            r.ctl = controls(LOAD_KIND[f3], PC_SEQ, 1'b1, LOAD_SRC[f3], MASK_NONE,
                             1'b1, AL_ADDI);
        end
        OPC_STORE: begin
          r.immediate_value = {{20{w[31]}}, w[31:25], w[11:7]};
          case (f3)
            F3_BYTE: r.ctl = controls(IK_SB, PC_SEQ, 1'b0, WB_ALU, MASK_BYTE, 1'b1,
                                      AL_STORE);
            F3_HALF: r.ctl = controls(IK_SH, PC_SEQ, 1'b0, WB_ALU, MASK_HALF, 1'b1,
                                      AL_STORE);
            F3_WORD: begin
              r.ctl = controls(IK_SW, PC_SEQ, 1'b0, WB_ALU, MASK_WORD, 1'b1, AL_STORE);
              r.dest_reg = '0;
            end
            default: ;
          endcase
        end
        OPC_JAL: begin
          r.ctl = controls(IK_JAL, PC_JAL, 1'b1, WB_LINK, MASK_NONE, 1'b0, AL_ADDI);
          r.immediate_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) begin
            r.ctl = controls(IK_JALR, PC_JALR, 1'b1, WB_LINK, MASK_NONE, 1'b1, AL_JALR);
            r.immediate_value = imm_i;
          end
        end
        OPC_BRANCH: begin
          // unused funct3 still keeps the branch PC select and immediate
          r.ctl = controls(BRANCH_KIND[f3], PC_BRANCH, 1'b0, WB_ALU, MASK_NONE, 1'b0,
                           BRANCH_OP[f3]);
          r.immediate_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_word(logic [31:0] w);
      decoded_q.push_back(decode_word(w));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: result with no decode waiting, got 0x%0h", $time, got);
        return;
      end
      want = decoded_q.pop_front();
      checked++;
      if (want.ctl.instr_kind < NUM_KINDS)
        kind_seen[want.ctl.instr_kind] = 1'b1;
      compare_field("instr_kind", 32'(want.ctl.instr_kind), 32'(got.ctl.instr_kind));
      compare_field("pc_mux_sel", 32'(want.ctl.pc_mux_sel), 32'(got.ctl.pc_mux_sel));
      compare_field("reg_write_en", 32'(want.ctl.reg_write_en),
                    32'(got.ctl.reg_write_en));
      compare_field("reg_input_sel", 32'(want.ctl.reg_input_sel),
                    32'(got.ctl.reg_input_sel));
      compare_field("pc_add_sel", 32'(want.ctl.pc_add_sel), 32'(got.ctl.pc_add_sel));
      compare_field("data_write_mask", 32'(want.ctl.data_write_mask),
                    32'(got.ctl.data_write_mask));
      compare_field("alu_input_sel", 32'(want.ctl.alu_input_sel),
                    32'(got.ctl.alu_input_sel));
      compare_field("alu_op", 32'(want.ctl.alu_op), 32'(got.ctl.alu_op));
      compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
      compare_field("src_reg_a", 32'(want.src_reg_a), 32'(got.src_reg_a));
      compare_field("src_reg_b", 32'(want.src_reg_b), 32'(got.src_reg_b));
      compare_field("immediate_value", want.immediate_value, got.immediate_value);
    endfunction

    function int kinds_reached();
      int n;
      n = 0;
      foreach (kind_seen[k])
        if (kind_seen[k])
          n++;
      return n;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rdc_in_if  in_if ();
  rdc_out_if out_if ();

  rv32im_decode_control_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  decode_board board;
  int          gap_pct;      // chance per item that the sender idles first
  bit          sink_stalls;  // lets the receiver drop ready in bursts

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] pack_fields(logic [6:0] f7, logic [4:0] rs2,
                                              logic [4:0] rs1, logic [2:0] f3,
                                              logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // Present one word from a falling edge and hold it until accepted. An idle
  // burst, if any, comes first, so valid never drops and rises in one step.
  task automatic drive_word(input logic [31:0] w);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.instr_word <= w;
    @(posedge clk_i);
    while (!in_if.ready)
      @(posedge clk_i);
    board.note_word(w);
    @(negedge clk_i);
  endtask

  // Receiver: mostly ready, with stall bursts while enabled
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Sample delivered results at the rising edge, before the block updates
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.ctl.instr_kind      = out_if.instr_kind;
      got.ctl.pc_mux_sel      = out_if.pc_mux_sel;
      got.ctl.reg_write_en    = out_if.reg_write_en;
      got.ctl.reg_input_sel   = out_if.reg_input_sel;
      got.ctl.pc_add_sel      = out_if.pc_add_sel;
      got.ctl.data_write_mask = out_if.data_write_mask;
      got.ctl.alu_input_sel   = out_if.alu_input_sel;
      got.ctl.alu_op          = out_if.alu_op;
      got.dest_reg            = out_if.dest_reg;
      got.src_reg_a           = out_if.src_reg_a;
      got.src_reg_b           = out_if.src_reg_b;
      got.immediate_value     = out_if.immediate_value;
      board.check_result(got);
    end
  end

  // Main sequence: reset, directed words, random words, drain
  initial begin
    logic [31:0] w;
    int          draw;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.instr_word = '0;
    gap_pct          = 20;
    sink_stalls      = 1'b1;
    board            = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, each format, and the unmatched funct codes
    drive_word(32'h0000_0000);                              // illegal, all zero
    drive_word(32'hFFFF_FFFF);                              // illegal, all one
    drive_word({20'hFFFFF, 5'd31, OPC_LUI});                // no sign extension
    drive_word({20'h80000, 5'd1, OPC_AUIPC});               // negative upper imm
    drive_word({20'h7FFFF, 5'd0, OPC_AUIPC});
    drive_word(pack_fields(7'h7F, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP_IMM));
    drive_word(pack_fields(F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_OP_IMM));
    drive_word(pack_fields(F7_ALT, 5'd3, 5'd4, F3_SLL, 5'd5, OPC_OP_IMM));
    drive_word(pack_fields(F7_BASE, 5'd17, 5'd6, F3_SR, 5'd7, OPC_OP_IMM));
    drive_word(pack_fields(F7_ALT, 5'd31, 5'd8, F3_SR, 5'd9, OPC_OP_IMM));
    drive_word(pack_fields(7'h7F, 5'd1, 5'd10, F3_SR, 5'd11, OPC_OP_IMM));
    drive_word(pack_fields(F7_BASE, 5'd12, 5'd13, F3_ADD, 5'd14, OPC_OP));
    drive_word(pack_fields(F7_ALT, 5'd31, 5'd0, F3_ADD, 5'd31, OPC_OP));
    drive_word(pack_fields(F7_ALT, 5'd15, 5'd16, F3_SR, 5'd17, OPC_OP));
    drive_word(pack_fields(F7_ALT, 5'd18, 5'd19, F3_SLL, 5'd20, OPC_OP));
    drive_word(pack_fields(F7_MULDIV, 5'd21, 5'd22, F3_ADD, 5'd23, OPC_OP));
    drive_word(pack_fields(7'h40, 5'd0, 5'd24, F3_BYTE, 5'd25, OPC_LOAD));
    drive_word(pack_fields(7'h3F, 5'd31, 5'd26, F3_UNUSED, 5'd27, OPC_LOAD));
    drive_word(pack_fields(7'h7F, 5'd1, 5'd2, F3_BYTE, 5'd31, OPC_STORE));
    drive_word(pack_fields(7'h3F, 5'd3, 5'd4, F3_HALF, 5'd0, OPC_STORE));
    drive_word(pack_fields(7'h55, 5'd5, 5'd6, F3_WORD, 5'd31, OPC_STORE));
    drive_word(pack_fields(7'h2A, 5'd7, 5'd8, F3_UNUSED, 5'd9, OPC_STORE));
    drive_word({20'hFFFFF, 5'd1, OPC_JAL});                 // all offset bits set
    drive_word(pack_fields(7'h7F, 5'd31, 5'd5, F3_ADD, 5'd1, OPC_JALR));
    drive_word(pack_fields(7'h7F, 5'd31, 5'd5, F3_SLL, 5'd1, OPC_JALR));
    drive_word(pack_fields(7'h7F, 5'd30, 5'd29, F3_ADD, 5'd31, OPC_BRANCH));
    drive_word(pack_fields(7'h01, 5'd2, 5'd3, F3_UNUSED, 5'd1, OPC_BRANCH));

    // Random: mostly real opcodes with random fields, some raw noise.
    // Change the idle pattern every 50 words; the tail runs without gaps.
    for (int i = 0; i < 1650; i++) begin
      if (i % 50 == 0) begin
        draw        = $urandom_range(0, 2);
        gap_pct     = (draw == 0) ? 0 : (draw == 1) ? 10 : 40;
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      if (i >= 1450) begin
        gap_pct     = 0;
        sink_stalls = 1'b0;
      end
      w = $urandom;
      if ($urandom_range(0, 99) < 85) begin
        w[6:0] = OPCODES[$urandom_range(0, 8)];
        case ($urandom_range(0, 3))
          0: w[31:25] = F7_BASE;
          1: w[31:25] = F7_ALT;
          2: w[31:25] = F7_MULDIV;
          default: ;
        endcase
      end
      drive_word(w);
    end
    in_if.valid <= 1'b0;

    // Drain, then let the two-stage pipe settle
    while (board.decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Decoded and checked %0d instruction words; %0d of %0d kinds reached.",
             board.checked, board.kinds_reached(), NUM_KINDS);
    if (board.errors == 0 && board.decoded_q.size() == 0) begin
      $display("rv32im_decode_control_top: match");
    end else begin
      $display("%0d field mismatches, %0d decodes left over", board.errors,
               board.decoded_q.size());
      $display("rv32im_decode_control_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout waiting for the decoder");
    $display("rv32im_decode_control_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rdc_pkg.sv
src/rdc_if.sv
src/rv32im_decode_control_top.sv
test/tb_rv32im_decode_control_top.sv
